>>> rtl/core/pexp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pexp_pkg
// Shared constants and types for the single-precision exponential core.
// ----------------------------------------------------------------------------
package pexp_pkg;

    localparam int FMA_LAT = 5;   // register stages in one fused multiply-add
    localparam int EXP_W   = 12;  // signed internal exponent width

    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
    localparam logic [31:0] POS_INF  = 32'h7F80_0000;
    localparam logic [31:0] QNAN     = 32'h7FC0_0000;
    localparam logic [31:0] MAGIC_R  = 32'h4B40_0000;
    localparam logic [31:0] LOG2E    = 32'h3FB8_AA3B;
    localparam logic [31:0] LN2_LO   = 32'h35BF_BE8E;
    localparam logic [31:0] LN2_HI   = 32'h3F31_7200;
    localparam logic [31:0] ONE_BITS = 32'h3F80_0000;
    localparam logic [31:0] PC1      = 32'h3C07_2010;
    localparam logic [31:0] PC2      = 32'h3D2B_9F17;
    localparam logic [31:0] PC3      = 32'h3E2A_AF33;
    localparam logic [31:0] PC4      = 32'h3EFF_FEDB;
    localparam logic [31:0] PC5      = 32'h3F7F_FFF6;
    localparam logic [31:0] NEG_BIAS = 32'h8200_0000;
    localparam logic [31:0] SCALE_HI = 32'h7F00_0000;
    localparam logic [31:0] F126     = 32'h42FC_0000;
    localparam logic [31:0] F192     = 32'h4340_0000;

    typedef struct packed {
        logic [31:0] k;
        logic [31:0] s2;
        logic [31:0] s1;
        logic        nan;
        logic        lo;
        logic        hi;
        logic        sat_pos;
    } t_side;

endpackage

>>> rtl/core/pexp_fma.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pexp_fma
// Pipelined binary32 fused multiply-add a*b+c, one rounding, nearest-even.
// Stages: unpack/multiply, normalise/order, align/add, count, round/pack.
// ----------------------------------------------------------------------------
module pexp_fma (
    input  logic        i_clk,
    input  logic        i_ce,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    input  logic [31:0] i_c,
    output logic [31:0] o_r
);

    localparam int EW = pexp_pkg::EXP_W;

    function automatic logic [5:0] msb62(input logic [61:0] v);
        logic [5:0] p;
        p = 6'd0;
        for (int i = 0; i < 62; i++) begin
            if (v[i]) begin
                p = 6'(i);
            end
        end
        return p;
    endfunction

    // ---------------- stage 1 ----------------
    logic           n1_byp;
    logic [31:0]    n1_bval;
    logic [47:0]    n1_pm;
    logic [EW-1:0]  n1_pe;
    logic [EW-1:0]  n1_ec;
    logic [23:0]    n1_mc;
    logic           n1_ps;
    logic           r1_byp, r1_ps, r1_sc, r1_cz;
    logic [31:0]    r1_bval;
    logic [47:0]    r1_pm;
    logic [EW-1:0]  r1_pe, r1_ec;
    logic [23:0]    r1_mc;

    logic [30:0] w_aa, w_ab, w_ac;
    logic        w_nan, w_ainf, w_binf, w_cinf;
    logic [23:0] w_ma, w_mb;
    logic [EW-1:0] w_ea, w_eb;

    always_comb begin
        w_aa   = i_a[30:0];
        w_ab   = i_b[30:0];
        w_ac   = i_c[30:0];
        w_nan  = (w_aa > pexp_pkg::POS_INF[30:0]) || (w_ab > pexp_pkg::POS_INF[30:0])
                 || (w_ac > pexp_pkg::POS_INF[30:0]);
        w_ainf = (w_aa == pexp_pkg::POS_INF[30:0]);
        w_binf = (w_ab == pexp_pkg::POS_INF[30:0]);
        w_cinf = (w_ac == pexp_pkg::POS_INF[30:0]);
        n1_ps  = i_a[31] ^ i_b[31];
        w_ma   = {(i_a[30:23] != 8'd0), i_a[22:0]};
        w_mb   = {(i_b[30:23] != 8'd0), i_b[22:0]};
        n1_mc  = {(i_c[30:23] != 8'd0), i_c[22:0]};
        w_ea   = (i_a[30:23] == 8'd0) ? -EW'(149) : $signed({4'b0, i_a[30:23]}) - EW'(150);
        w_eb   = (i_b[30:23] == 8'd0) ? -EW'(149) : $signed({4'b0, i_b[30:23]}) - EW'(150);
        n1_ec  = (i_c[30:23] == 8'd0) ? -EW'(149) : $signed({4'b0, i_c[30:23]}) - EW'(150);
        n1_pe  = w_ea + w_eb;
        n1_pm  = w_ma * w_mb;
        n1_byp  = 1'b1;
        n1_bval = i_c;
        if (w_nan) begin
            n1_bval = pexp_pkg::QNAN;
        end else if (w_ainf || w_binf) begin
            if (w_aa == 31'd0 || w_ab == 31'd0) begin
                n1_bval = pexp_pkg::QNAN;
            end else if (w_cinf && (i_c[31] != n1_ps)) begin
                n1_bval = pexp_pkg::QNAN;
            end else begin
                n1_bval = {n1_ps, pexp_pkg::POS_INF[30:0]};
            end
        end else if (w_cinf) begin
            n1_bval = i_c;
        end else if (w_ma == 24'd0 || w_mb == 24'd0) begin
            if (n1_mc == 24'd0) begin
                n1_bval = {n1_ps & i_c[31], 31'd0};
            end else begin
                n1_bval = i_c;
            end
        end else begin
            n1_byp = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_byp  <= n1_byp;
            r1_bval <= n1_bval;
            r1_pm   <= n1_pm;
            r1_pe   <= n1_pe;
            r1_ps   <= n1_ps;
            r1_mc   <= n1_mc;
            r1_ec   <= n1_ec;
            r1_sc   <= i_c[31];
            r1_cz   <= (n1_mc == 24'd0);
        end
    end

    // ---------------- stage 2 ----------------
    logic [5:0]    w_pp, w_pc, w_shp, w_shc;
    logic [60:0]   w_pmn, w_mcn;
    logic [EW-1:0] w_pen, w_ecn, w_d;
    logic [60:0]   n2_big, n2_small;
    logic [EW-1:0] n2_ebig, n2_esm;
    logic          n2_sbig, n2_ssm;
    logic [5:0]    n2_dc;
    logic          r2_byp, r2_sbig, r2_ssm;
    logic [31:0]   r2_bval;
    logic [60:0]   r2_big, r2_small;
    logic [EW-1:0] r2_ebig;
    logic [5:0]    r2_dc;

    always_comb begin
        w_pp  = msb62({14'd0, r1_pm});
        w_pc  = msb62({38'd0, r1_mc});
        w_shp = 6'd60 - w_pp;
        w_shc = 6'd60 - w_pc;
        w_pmn = {13'd0, r1_pm} << w_shp;
        w_mcn = {37'd0, r1_mc} << w_shc;
        w_pen = r1_pe - $signed({{(EW-6){1'b0}}, w_shp});
        w_ecn = r1_ec - $signed({{(EW-6){1'b0}}, w_shc});
        if (r1_cz) begin
            n2_big = w_pmn; n2_ebig = w_pen; n2_sbig = r1_ps;
            n2_small = 61'd0; n2_esm = w_pen; n2_ssm = r1_ps;
        end else if ($signed(w_pen) > $signed(w_ecn)
                     || (w_pen == w_ecn && w_pmn >= w_mcn)) begin
            n2_big = w_pmn; n2_ebig = w_pen; n2_sbig = r1_ps;
            n2_small = w_mcn; n2_esm = w_ecn; n2_ssm = r1_sc;
        end else begin
            n2_big = w_mcn; n2_ebig = w_ecn; n2_sbig = r1_sc;
            n2_small = w_pmn; n2_esm = w_pen; n2_ssm = r1_ps;
        end
        w_d   = n2_ebig - n2_esm;
        n2_dc = ($signed(w_d) > $signed(EW'(62))) ? 6'd63 : w_d[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r2_byp   <= r1_byp;
            r2_bval  <= r1_bval;
            r2_big   <= n2_big;
            r2_small <= n2_small;
            r2_ebig  <= n2_ebig;
            r2_sbig  <= n2_sbig;
            r2_ssm   <= n2_ssm;
            r2_dc    <= n2_dc;
        end
    end

    // ---------------- stage 3 ----------------
    logic [60:0]   w_msk, w_sal;
    logic [61:0]   n3_r;
    logic          n3_byp;
    logic [31:0]   n3_bval;
    logic          r3_byp, r3_sbig;
    logic [31:0]   r3_bval;
    logic [61:0]   r3_r;
    logic [EW-1:0] r3_ebig;

    always_comb begin
        w_msk = ~({61{1'b1}} << r2_dc);
        if (r2_dc == 6'd63) begin
            w_sal = 61'd1;
        end else begin
            w_sal = (r2_small >> r2_dc) | {60'd0, |(r2_small & w_msk)};
        end
        if (r2_sbig == r2_ssm) begin
            n3_r = {1'b0, r2_big} + {1'b0, w_sal};
        end else begin
            n3_r = {1'b0, r2_big} - {1'b0, w_sal};
        end
        n3_byp  = r2_byp;
        n3_bval = r2_bval;
        if (!r2_byp && n3_r == 62'd0) begin
            n3_byp  = 1'b1;
            n3_bval = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r3_byp  <= n3_byp;
            r3_bval <= n3_bval;
            r3_r    <= n3_r;
            r3_ebig <= r2_ebig;
            r3_sbig <= r2_sbig;
        end
    end

    // ---------------- stage 4 ----------------
    logic [5:0]    w_p4;
    logic [EW-1:0] n4_emsb, w_ex;
    logic [5:0]    n4_extra;
    logic          r4_byp, r4_s;
    logic [31:0]   r4_bval;
    logic [61:0]   r4_rn;
    logic [EW-1:0] r4_emsb;
    logic [5:0]    r4_extra;

    always_comb begin
        w_p4    = msb62(r3_r);
        n4_emsb = r3_ebig + $signed({{(EW-6){1'b0}}, w_p4});
        w_ex    = -EW'(126) - n4_emsb;
        if ($signed(w_ex) <= 0) begin
            n4_extra = 6'd0;
        end else if ($signed(w_ex) > $signed(EW'(63))) begin
            n4_extra = 6'd63;
        end else begin
            n4_extra = w_ex[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r4_byp   <= r3_byp;
            r4_bval  <= r3_bval;
            r4_rn    <= r3_r << (6'd61 - w_p4);
            r4_emsb  <= n4_emsb;
            r4_extra <= n4_extra;
            r4_s     <= r3_sbig;
        end
    end

    // ---------------- stage 5 ----------------
    logic [61:0]   w_rs, w_m5k;
    logic          w_g, w_st, w_up;
    logic [24:0]   w_mr;
    logic [23:0]   w_mm;
    logic [EW-1:0] w_le, w_be;
    logic [31:0]   n5_y;
    logic [31:0]   r5_y;

    always_comb begin
        w_rs  = r4_rn >> r4_extra;
        w_m5k = ~({62{1'b1}} << r4_extra);
        w_g   = w_rs[37];
        w_st  = (|w_rs[36:0]) | (|(r4_rn & w_m5k));
        w_up  = w_g & (w_st | w_rs[38]);
        w_mr  = {1'b0, w_rs[61:38]} + {24'd0, w_up};
        w_le  = r4_emsb - EW'(23) + $signed({{(EW-6){1'b0}}, r4_extra});
        if (w_mr[24]) begin
            w_mm = w_mr[24:1];
            w_le = w_le + EW'(1);
        end else begin
            w_mm = w_mr[23:0];
        end
        w_be = w_le + EW'(149);
        if (r4_byp) begin
            n5_y = r4_bval;
        end else if (w_mm == 24'd0) begin
            n5_y = {r4_s, 31'd0};
        end else if ($signed(w_be) >= $signed(EW'(254))) begin
            n5_y = {r4_s, pexp_pkg::POS_INF[30:0]};
        end else begin
            n5_y = {r4_s, {w_be[7:0], 23'd0} + {7'd0, w_mm}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r5_y <= n5_y;
        end
    end

    assign o_r = r5_y;

endmodule

>>> rtl/core/poly_exp_single_precision_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poly_exp_single_precision_core
// Streaming binary32 e^x: magic-add range reduction, degree-5 polynomial
// by fused multiply-adds, exponent insertion, split scaling and saturation.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel takes one binary32 argument per word on s_axis; master
//   channel returns e^x as a binary32 word on m_axis, in order.
//   The datapath is ten fused multiply-add levels of FMA_LAT (5) stages
//   each plus one output register. A new word is taken every cycle while
//   the pipeline is not stalled; throughput is then one word per clock,
//   set by the fully pipelined multiply-add units.
//   Reset (i_rst_n low, synchronous) clears every valid bit; data
//   registers are not reset. When the receiver holds i_m_axis_tready low
//   with a word waiting, the whole pipeline freezes and o_s_axis_tready
//   drops; bubbles in flight are not squeezed out. Nothing is lost or
//   repeated across a stall.
//   NaN arguments give 0x7FC00000; large arguments saturate to +inf or +0.
// ----------------------------------------------------------------------------
module poly_exp_single_precision_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] x_bits
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // [31:0] y_bits
);

    localparam int F   = pexp_pkg::FMA_LAT;
    localparam int TOT = 10 * F + 1;

    logic          w_ce;
    logic [TOT-1:0] r_vld;
    logic [31:0]   r_y;

    logic [31:0] w_z, w_n, w_nn, w_t, w_b, w_u, w_q1, w_q2, w_m5;
    logic [31:0] w_r1, w_j, w_a, w_bm, w_c, w_d;

    logic [31:0] r_xd  [0:2*F-1];
    logic [31:0] r_zd  [0:F-1];
    logic [31:0] r_nnd [0:F-1];
    logic [31:0] r_ud  [0:F-1];
    logic [31:0] r_m5d [0:F-1];
    logic [31:0] r_ad  [0:2*F-1];
    pexp_pkg::t_side r_sd [0:8*F-1];

    pexp_pkg::t_side w_side;
    logic [31:0] w_e, w_g, w_nabs, n_y;

    assign w_ce            = ~r_vld[TOT-1] | i_m_axis_tready;
    assign o_s_axis_tready = w_ce;
    assign o_m_axis_tvalid = r_vld[TOT-1];
    assign o_m_axis_tdata  = r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[TOT-2:0], i_s_axis_tvalid};
        end
    end

    assign w_nn = w_n ^ pexp_pkg::SIGN_BIT;

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_xd[0]  <= i_s_axis_tdata;
            r_zd[0]  <= w_z;
            r_nnd[0] <= w_nn;
            r_ud[0]  <= w_u;
            r_m5d[0] <= w_m5;
            r_ad[0]  <= w_a;
            r_sd[0]  <= w_side;
            for (int i = 1; i < 2 * F; i++) begin
                r_xd[i] <= r_xd[i-1];
                r_ad[i] <= r_ad[i-1];
            end
            for (int i = 1; i < F; i++) begin
                r_zd[i]  <= r_zd[i-1];
                r_nnd[i] <= r_nnd[i-1];
                r_ud[i]  <= r_ud[i-1];
                r_m5d[i] <= r_m5d[i-1];
            end
            for (int i = 1; i < 8 * F; i++) begin
                r_sd[i] <= r_sd[i-1];
            end
        end
    end

    // scale factors and range flags, formed once n is known
    always_comb begin
        w_e            = r_zd[F-1] << 23;
        w_nabs         = {1'b0, w_n[30:0]};
        w_g            = (w_n[31] || w_nabs == 32'd0) ? pexp_pkg::NEG_BIAS : 32'd0;
        w_side.k       = w_e + pexp_pkg::ONE_BITS;
        w_side.s1      = w_g + pexp_pkg::SCALE_HI;
        w_side.s2      = w_e - w_g;
        w_side.nan     = ({1'b0, r_xd[2*F-1][30:0]} > pexp_pkg::POS_INF);
        w_side.lo      = (w_nabs <= pexp_pkg::F126);
        w_side.hi      = (w_nabs > pexp_pkg::F192);
        w_side.sat_pos = (w_g == 32'd0);
    end

    pexp_fma u_fz  (.i_clk, .i_ce(w_ce), .i_a(i_s_axis_tdata), .i_b(pexp_pkg::LOG2E),
                    .i_c(pexp_pkg::MAGIC_R), .o_r(w_z));
    pexp_fma u_fn  (.i_clk, .i_ce(w_ce), .i_a(w_z), .i_b(pexp_pkg::ONE_BITS),
                    .i_c(pexp_pkg::MAGIC_R ^ pexp_pkg::SIGN_BIT), .o_r(w_n));
    pexp_fma u_ft  (.i_clk, .i_ce(w_ce), .i_a(w_nn), .i_b(pexp_pkg::LN2_HI),
                    .i_c(r_xd[2*F-1]), .o_r(w_t));
    pexp_fma u_fb  (.i_clk, .i_ce(w_ce), .i_a(r_nnd[F-1]), .i_b(pexp_pkg::LN2_LO),
                    .i_c(w_t), .o_r(w_b));
    pexp_fma u_fu  (.i_clk, .i_ce(w_ce), .i_a(w_b), .i_b(w_b),
                    .i_c(pexp_pkg::SIGN_BIT), .o_r(w_u));
    pexp_fma u_fq1 (.i_clk, .i_ce(w_ce), .i_a(pexp_pkg::PC1), .i_b(w_b),
                    .i_c(pexp_pkg::PC2), .o_r(w_q1));
    pexp_fma u_fq2 (.i_clk, .i_ce(w_ce), .i_a(pexp_pkg::PC3), .i_b(w_b),
                    .i_c(pexp_pkg::PC4), .o_r(w_q2));
    pexp_fma u_fm5 (.i_clk, .i_ce(w_ce), .i_a(pexp_pkg::PC5), .i_b(w_b),
                    .i_c(pexp_pkg::SIGN_BIT), .o_r(w_m5));
    pexp_fma u_fr1 (.i_clk, .i_ce(w_ce), .i_a(w_q1), .i_b(w_u),
                    .i_c(w_q2), .o_r(w_r1));
    pexp_fma u_fj  (.i_clk, .i_ce(w_ce), .i_a(w_r1), .i_b(r_ud[F-1]),
                    .i_c(r_m5d[F-1]), .o_r(w_j));
    pexp_fma u_fa  (.i_clk, .i_ce(w_ce), .i_a(w_j), .i_b(r_sd[5*F-1].k),
                    .i_c(r_sd[5*F-1].k), .o_r(w_a));
    pexp_fma u_fbm (.i_clk, .i_ce(w_ce), .i_a(r_sd[5*F-1].s2), .i_b(w_j),
                    .i_c(pexp_pkg::SIGN_BIT), .o_r(w_bm));
    pexp_fma u_fc  (.i_clk, .i_ce(w_ce), .i_a(w_bm), .i_b(pexp_pkg::ONE_BITS),
                    .i_c(r_sd[6*F-1].s2), .o_r(w_c));
    pexp_fma u_fd  (.i_clk, .i_ce(w_ce), .i_a(w_c), .i_b(r_sd[7*F-1].s1),
                    .i_c(pexp_pkg::SIGN_BIT), .o_r(w_d));

    always_comb begin
        if (r_sd[8*F-1].nan) begin
            n_y = pexp_pkg::QNAN;
        end else if (r_sd[8*F-1].lo) begin
            n_y = r_ad[2*F-1];
        end else if (r_sd[8*F-1].hi) begin
            n_y = r_sd[8*F-1].sat_pos ? pexp_pkg::POS_INF : 32'd0;
        end else begin
            n_y = w_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_y <= n_y;
        end
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams binary32 arguments into the e^x core with random gaps and receiver
// stalls, and checks every returned word against a bit-exact predictor built
// on a single-rounding fused multiply-add.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int PIPE_LAT  = 51;
    localparam int IDLE_LIM  = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata = '0;   // [31:0] x_bits
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;        // [31:0] y_bits

    logic [31:0] arg_q[$];
    logic [31:0] exp_q[$];
    int          n_fail = 0;
    bit          stim_done = 0;
    bit          calm = 0;
    bit          in_took = 0;
    int          src_gap = 0;
    int          snk_gap = 0;
    int          hold_off = 0;
    int          idle_cnt = 0;

    always #5 i_clk = ~i_clk;

    poly_exp_single_precision_core u_dut (.*);

    // ---- predictor ----
    function automatic void split(input logic [31:0] u, output logic s,
                                  output logic [63:0] m, output int e);
        s = u[31];
        m = {41'd0, u[22:0]};
        if (u[30:23] == 8'd0) e = -149;
        else begin
            m[23] = 1'b1;
            e = int'(u[30:23]) - 150;
        end
    endfunction

    function automatic logic [31:0] rnd(input logic s, input logic [63:0] r, input int e);
        int p, sh, le;
        logic [63:0] m, rem, half;
        p = 63;
        while (p > 0 && !r[p]) p--;
        sh = p - 23;
        if (sh < -149 - e) sh = -149 - e;
        if (sh <= 0) m = r << (-sh);
        else if (sh > 62) m = 0;
        else begin
            rem  = r & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            m = r >> sh;
            if (rem > half || (rem == half && m[0])) m++;
        end
        le = e + sh;
        if (m >= 64'h100_0000) begin
            m >>= 1;
            le++;
        end
        if (m == 0) return {s, 31'd0};
        if (le + 150 >= 255) return {s, 31'd0} | pexp_pkg::POS_INF;
        return {s, 31'd0} + (32'(le + 149) << 23) + m[31:0];
    endfunction

    function automatic logic [31:0] fma32(input logic [31:0] a, b, c);
        logic sa, sb, sc, ps, sbig, ssm;
        logic [63:0] ma, mb, mc, pm, big, sm, r;
        int ea, eb, ec, pe, ebig, esm, d;
        logic [30:0] aa, ab, ac, inf;
        aa  = a[30:0];
        ab  = b[30:0];
        ac  = c[30:0];
        inf = pexp_pkg::POS_INF[30:0];
        if (aa > inf || ab > inf || ac > inf) return pexp_pkg::QNAN;
        ps = a[31] ^ b[31];
        if (aa == inf || ab == inf) begin
            if (aa == 0 || ab == 0) return pexp_pkg::QNAN;
            if (ac == inf && c[31] != ps) return pexp_pkg::QNAN;
            return {ps, inf};
        end
        if (ac == inf) return c;
        split(a, sa, ma, ea);
        split(b, sb, mb, eb);
        split(c, sc, mc, ec);
        pm = ma * mb;
        pe = ea + eb;
        if (pm == 0) begin
            if (mc == 0) return {ps & sc, 31'd0};
            return c;
        end
        if (mc == 0) return rnd(ps, pm, pe);
        while (!pm[60]) begin
            pm <<= 1;
            pe--;
        end
        while (!mc[60]) begin
            mc <<= 1;
            ec--;
        end
        if (pe > ec || (pe == ec && pm >= mc)) begin
            big = pm; ebig = pe; sbig = ps; sm = mc; esm = ec; ssm = sc;
        end else begin
            big = mc; ebig = ec; sbig = sc; sm = pm; esm = pe; ssm = ps;
        end
        d = ebig - esm;
        if (d > 62) sm = 1;
        else if (d > 0) sm = (sm >> d) | 64'((sm & ((64'd1 << d) - 1)) != 0);
        if (sbig == ssm) r = big + sm;
        else begin
            r = big - sm;
            if (r == 0) return '0;
        end
        return rnd(sbig, r, ebig);
    endfunction

    function automatic logic [31:0] exp_of(input logic [31:0] x);
        logic [31:0] z, n, nn, b, e, k, u, j, na, g, s1, s2;
        if (x[30:0] > pexp_pkg::POS_INF[30:0]) return pexp_pkg::QNAN;
        z  = fma32(x, pexp_pkg::LOG2E, pexp_pkg::MAGIC_R);
        n  = fma32(z, pexp_pkg::ONE_BITS, pexp_pkg::MAGIC_R ^ pexp_pkg::SIGN_BIT);
        nn = n ^ pexp_pkg::SIGN_BIT;
        b  = fma32(nn, pexp_pkg::LN2_LO, fma32(nn, pexp_pkg::LN2_HI, x));
        e  = z << 23;
        k  = e + pexp_pkg::ONE_BITS;
        na = n & ~pexp_pkg::SIGN_BIT;
        u  = fma32(b, b, pexp_pkg::SIGN_BIT);
        j  = fma32(fma32(fma32(pexp_pkg::PC1, b, pexp_pkg::PC2), u,
                         fma32(pexp_pkg::PC3, b, pexp_pkg::PC4)), u,
                   fma32(pexp_pkg::PC5, b, pexp_pkg::SIGN_BIT));
        if (na <= pexp_pkg::F126) return fma32(j, k, k);
        g  = (n[31] || na == 0) ? pexp_pkg::NEG_BIAS : 32'd0;
        s1 = g + pexp_pkg::SCALE_HI;
        s2 = e - g;
        if (na > pexp_pkg::F192) return fma32(s1, s1, pexp_pkg::SIGN_BIT);
        return fma32(fma32(fma32(s2, j, pexp_pkg::SIGN_BIT), pexp_pkg::ONE_BITS, s2),
                     s1, pexp_pkg::SIGN_BIT);
    endfunction

    // ---- stimulus ----
    function automatic logic [31:0] rand_arg();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return {1'b0, 8'(int'($urandom_range(100, 133))), 23'($urandom)} |
                            {1'($urandom), 31'd0};
        if (sel < 8) return {1'($urandom), 8'(int'($urandom_range(130, 134))), 23'($urandom)};
        return $urandom;
    endfunction

    initial begin
        logic [31:0] dir[] = '{32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
            32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001,
            32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001, 32'h8000_0001, 32'h42B0_0000,
            32'hC2B0_0000, 32'h42FE_0000, 32'hC2FE_0000, 32'h4300_0000, 32'hC300_0000,
            32'h4305_0000, 32'hC305_0000, 32'h42B1_7218, 32'hC2CF_F1B5, 32'hC2CE_8ED0,
            32'h3400_0000};
        foreach (dir[i]) arg_q.push_back(dir[i]);
        repeat (1800) arg_q.push_back(rand_arg());
    end

    // ---- driver ----
    always @(posedge i_clk) begin
        in_took <= i_s_axis_tvalid && o_s_axis_tready;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || in_took) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (arg_q.size() > 0) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= arg_q.pop_front();
                if (!calm && $urandom_range(0, 9) == 0) src_gap <= $urandom_range(1, 19);
            end else begin
                i_s_axis_tvalid <= 1'b0;
                stim_done <= 1'b1;
            end
        end
        calm <= arg_q.size() < 300;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_m_axis_tready <= 1'b0;
        end else if (arg_q.size() == 1000) begin
            hold_off <= 300;
            i_m_axis_tready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap <= snk_gap - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 9) == 0) snk_gap <= $urandom_range(1, 19);
        end
    end

    // ---- monitor ----
    always @(posedge i_clk) begin
        logic [31:0] want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) exp_q.push_back(exp_of(i_s_axis_tdata));
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (exp_q.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual %h",
                             $realtime, o_m_axis_tdata);
                    n_fail++;
                end else begin
                    want = exp_q.pop_front();
                    if (want !== o_m_axis_tdata) begin
                        $display("%0t: y_bits mismatch, expected %h, actual %h",
                                 $realtime, want, o_m_axis_tdata);
                        n_fail++;
                    end
                end
            end
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                idle_cnt <= 0;
            else
                idle_cnt <= idle_cnt + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cnt >= IDLE_LIM) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (stim_done && exp_q.size() == 0);
        repeat (PIPE_LAT + 10) @(posedge i_clk);
        if (n_fail == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule

>>> sim.f
rtl/core/pexp_pkg.sv
rtl/core/pexp_fma.sv
rtl/core/poly_exp_single_precision_core.sv
test/tb_top.sv
